### hw/rtl/ptd_pkg.sv
// Shared types and constants for the trial-division primality tester.
package ptd_pkg;

    localparam int NUMBER_WIDTH = 32;
    localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EVAL  = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;      // latch number, divisor back to three
        logic div_init;  // start a division of number by the divisor
        logic div_step;  // one restoring division step
        logic d_inc;     // next odd divisor
    } ptd_cmd_t;

    typedef struct packed {
        logic n_is_two;
        logic n_trivial;  // zero, one or even
        logic div_last;   // this step finishes the quotient
        logic d_gt_quo;   // divisor above number / divisor
        logic rem_zero;
    } ptd_status_t;

endpackage

### hw/rtl/ptd_datapath.sv
// Datapath: number and divisor registers and a bit-serial restoring divider.
module ptd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ptd_pkg::NUMBER_WIDTH-1:0] number,
    input  ptd_pkg::ptd_cmd_t                 cmd,
    output ptd_pkg::ptd_status_t              status
);

    logic [ptd_pkg::NUMBER_WIDTH-1:0] n_reg;
    logic [ptd_pkg::NUMBER_WIDTH-1:0] d_reg;
    logic [ptd_pkg::NUMBER_WIDTH-1:0] rem_reg;
    logic [ptd_pkg::NUMBER_WIDTH-1:0] quo_reg;
    logic [ptd_pkg::CNT_WIDTH-1:0]    cnt_reg;

    logic [ptd_pkg::NUMBER_WIDTH:0]   rem_shift;
    logic [ptd_pkg::NUMBER_WIDTH:0]   rem_diff;
    logic                             fits;
    logic [ptd_pkg::NUMBER_WIDTH-1:0] rem_next;
    logic [ptd_pkg::NUMBER_WIDTH-1:0] quo_next;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[ptd_pkg::NUMBER_WIDTH-1]};
        rem_diff  = rem_shift - {1'b0, d_reg};
        fits      = (rem_shift >= {1'b0, d_reg});
        // remainder stays below the divisor, so the top bit drops
        rem_next  = fits ? rem_diff[ptd_pkg::NUMBER_WIDTH-1:0]
                         : rem_shift[ptd_pkg::NUMBER_WIDTH-1:0];
        quo_next  = {quo_reg[ptd_pkg::NUMBER_WIDTH-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg <= number;
            d_reg <= ptd_pkg::NUMBER_WIDTH'(3);
        end
        else if (cmd.d_inc)
        begin
            d_reg <= d_reg + ptd_pkg::NUMBER_WIDTH'(2);
        end

        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= n_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + ptd_pkg::CNT_WIDTH'(1);
        end
    end

    always_comb
    begin
        status.n_is_two  = (n_reg == ptd_pkg::NUMBER_WIDTH'(2));
        status.n_trivial = (n_reg[ptd_pkg::NUMBER_WIDTH-1:1] == '0) || !n_reg[0];
        status.div_last  = (cnt_reg == ptd_pkg::CNT_WIDTH'(ptd_pkg::NUMBER_WIDTH - 1));
        status.d_gt_quo  = (d_reg > quo_reg);
        status.rem_zero  = (rem_reg == '0);
    end

endmodule

### hw/rtl/ptd_ctrl.sv
// Controller: sequences the divisor trials and issues the result strobe.
module ptd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ptd_pkg::ptd_status_t status,
    output ptd_pkg::ptd_cmd_t    cmd,
    output logic                 busy,
    output logic                 done,
    output logic                 is_prime
);

    ptd_pkg::state_t state_reg, state_next;
    logic            done_reg, done_next;
    logic            prime_reg, prime_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        cmd        = '0;
        unique case (state_reg)
            ptd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ptd_pkg::ST_CHECK;
                end
            end
            ptd_pkg::ST_CHECK:
            begin
                if (status.n_is_two)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = ptd_pkg::ST_IDLE;
                end
                else if (status.n_trivial)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = ptd_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ptd_pkg::ST_DIV;
                end
            end
            ptd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ptd_pkg::ST_EVAL;
                end
            end
            ptd_pkg::ST_EVAL:
            begin
                // divisor squared past the number: no factor left
                if (status.d_gt_quo)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = ptd_pkg::ST_IDLE;
                end
                else if (status.rem_zero)
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b0;
                    state_next = ptd_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.d_inc    = 1'b1;
                    cmd.div_init = 1'b1;
                    state_next   = ptd_pkg::ST_DIV;
                end
            end
            default:
            begin
                state_next = ptd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptd_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            prime_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            prime_reg <= prime_next;
        end
    end

    assign busy     = (state_reg != ptd_pkg::ST_IDLE);
    assign done     = done_reg;
    assign is_prime = prime_reg;

endmodule

### hw/rtl/prime_trial_division_top.sv
// Top level of the trial-division primality tester.
// Numbers 0, 1, 2 and even numbers are settled in the check state; otherwise each
// odd divisor tried runs a full bit-serial division and then an evaluation, and the
// search ends on a factor or once the divisor exceeds number / divisor.
// One item at a time: busy is high from acceptance until the done strobe.
// Reset clears the controller and the strobe; done pulses for one cycle, unstalled.
module prime_trial_division_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ptd_pkg::NUMBER_WIDTH-1:0] number,
    output logic                              busy,
    output logic                              done,
    output logic                              is_prime
);

    ptd_pkg::ptd_cmd_t    cmd;
    ptd_pkg::ptd_status_t status;

    ptd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done),
        .is_prime (is_prime)
    );

    ptd_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number),
        .cmd    (cmd),
        .status (status)
    );

endmodule

### dv/tb_top.sv
// Testbench for the trial-division primality tester: predicted flags checked against results.
`timescale 1ns / 100ps

module tb_top;

    localparam int NW = (ptd_pkg::NUMBER_WIDTH < 1) ? 1 :
                        (ptd_pkg::NUMBER_WIDTH > 64) ? 64 : ptd_pkg::NUMBER_WIDTH;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int TAIL_CYCLES   = 40;
    localparam int ODD_TRY_CAP   = 300;
    localparam int RANDOM_ITEMS  = 20;   // per idling phase

    typedef struct {
        logic [63:0] number;
        bit          flag;
    } prime_entry_t;

    class flag_ledger;
        prime_entry_t pending_flags[$];
        int unsigned  errors;

        function new();
            errors = 0;
        endfunction

        // Trial division at the block's width; tries counts the divisors tested.
        static function bit trial_divide(input logic [63:0] raw, output int unsigned tries);
            logic [63:0] n;
            logic [63:0] d;
            n = raw & (~64'd0 >> (64 - NW));
            tries = 0;
            if (n == 64'd2)
                return 1'b1;
            if (n < 64'd2 || n[0] == 1'b0)
                return 1'b0;
            for (d = 64'd3; d <= n / d; d += 64'd2)
            begin
                tries++;
                if (n % d == 64'd0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function int unsigned pending();
            return pending_flags.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        task note_number(logic [63:0] number);
            prime_entry_t e;
            int unsigned  tries;
            e.number = number;
            e.flag   = trial_divide(number, tries);
            pending_flags.push_back(e);
        endtask

        task check_result(logic got);
            prime_entry_t e;
            if (pending_flags.size() == 0)
            begin
                report_mismatch($sformatf("is_prime=%b with no item pending", got));
                return;
            end
            e = pending_flags.pop_front();
            if (got !== e.flag)
                report_mismatch($sformatf("number %0d: is_prime=%b, want %b",
                                          e.number, got, e.flag));
        endtask
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic [ptd_pkg::NUMBER_WIDTH-1:0] number;
    logic                             busy;
    logic                             done;
    logic                             is_prime;

    flag_ledger  board;
    int unsigned cycles;

    prime_trial_division_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .number   (number),
        .busy     (busy),
        .done     (done),
        .is_prime (is_prime)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample handshakes with pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_number(64'(number));
            if (done)
                board.check_result(is_prime);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Mostly cheap numbers; wide values carry a small factor or need few odd trials, so they finish quickly.
    function automatic logic [63:0] pick_number();
        logic [63:0] n;
        int unsigned sel;
        int unsigned tries;
        int unsigned f;
        sel = $urandom_range(99);
        if (sel < 55)
            n = 64'($urandom_range(4095));
        else if (sel < 70)
            n = 64'($urandom_range(32'h000F_FFFF));
        else if (sel < 92)
        begin
            case ($urandom_range(3))
                0: f = 2;
                1: f = 3;
                2: f = 5;
                default: f = 7;
            endcase
            n = (64'($urandom) / 64'(f)) * 64'(f);
        end
        else
        begin
            do
            begin
                n = 64'($urandom | 32'd1);
                void'(flag_ledger::trial_divide(n, tries));
            end
            while (tries > ODD_TRY_CAP);
        end
        return n;
    endfunction

    task automatic send_number(logic [63:0] value, int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        number <= value[ptd_pkg::NUMBER_WIDTH-1:0];
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    logic [63:0] directed_numbers[] = '{
        64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd25, 64'd49, 64'd121,
        64'd97, 64'd341, 64'd65521, 64'd65535, 64'd65537,
        64'd16752649,            // square of a prime: divisor squared equals number
        64'd16777213,
        64'hFFFF_FFFF, 64'hFFFF_FFFE, 64'h8000_0000, 64'h8000_0001,
        64'h5555_5555, 64'hAAAA_AAAA
    };

    int unsigned idle_pcts[4] = '{0, 67, 0, 25};

    initial
    begin
        board  = new();
        cycles = 0;
        rst_n  = 1'b0;
        start  = 1'b0;
        number = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_numbers[i])
            send_number(directed_numbers[i], 0);
        start <= 1'b0;
        @(posedge clk);
        // sender holds off until everything is back
        wait_drained();

        foreach (idle_pcts[p])
            for (int k = 0; k < RANDOM_ITEMS; k++)
                send_number(pick_number(), idle_pcts[p]);
        start <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
